/* sv/csa_pkg.sv */
// shared types, constants and helper functions for the clock, stopwatch and alarm block
`timescale 1ns / 1ps

package csa_pkg;

   localparam int LAP_DEPTH   = 4;
   localparam int COUNT_WIDTH = 24;

   localparam logic [6:0] PHASE_TOP  = 7'd99;   // 100 ticks of 10 ms per second
   localparam logic [4:0] HOUR_TOP   = 5'd23;
   localparam logic [5:0] MINUTE_TOP = 6'd59;
   localparam logic [5:0] SECOND_TOP = 6'd59;
   localparam logic [6:0] SNOOZE_MIN = 7'd5;
   localparam logic [6:0] HOUR_MINS  = 7'd60;

   typedef enum logic [1:0] {
      FUNC_TICK       = 2'd0,
      FUNC_LOAD_CLOCK = 2'd1,
      FUNC_LOAD_ALARM = 2'd2,
      FUNC_NOP        = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      MODE_TIMEKEEP = 3'd0,
      MODE_SET      = 3'd1,
      MODE_WATCH    = 3'd2,
      MODE_RING     = 3'd3,
      MODE_OTHER    = 3'd4
   } mode_type;

   typedef struct packed {
      logic [1:0] func;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
      logic       alarm_on;
      logic       mode_write;
      logic [2:0] mode_value;
      logic       start_stop;
      logic       reset_button;
   } req_type;

   typedef struct packed {
      logic [4:0]             clock_hour;
      logic [5:0]             clock_minute;
      logic [5:0]             clock_second;
      logic                   clock_update;
      logic [COUNT_WIDTH-1:0] stopwatch_shown;
      logic [COUNT_WIDTH-1:0] lap_newest;
      logic [COUNT_WIDTH-1:0] lap_second;
      logic [COUNT_WIDTH-1:0] lap_third;
      logic [COUNT_WIDTH-1:0] lap_oldest;
      logic                   stopwatch_update;
      mode_type               mode_now;
   } rsp_type;

   function automatic mode_type sat_mode(input logic [2:0] value);
      mode_type m;
      unique case (value)
         3'd0:    m = MODE_TIMEKEEP;
         3'd1:    m = MODE_SET;
         3'd2:    m = MODE_WATCH;
         3'd3:    m = MODE_RING;
         default: m = MODE_OTHER;
      endcase
      return m;
   endfunction

   function automatic logic [4:0] sat_hour(input logic [4:0] value);
      return (value > HOUR_TOP) ? HOUR_TOP : value;
   endfunction

   function automatic logic [5:0] sat_sixty(input logic [5:0] value);
      return (value > MINUTE_TOP) ? MINUTE_TOP : value;
   endfunction

endpackage

/* sv/csa_core.sv */
// timekeeping, stopwatch and alarm state with its single-pass next-state logic
`timescale 1ns / 1ps

module csa_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  csa_pkg::req_type item,
   output csa_pkg::rsp_type result
);
   import csa_pkg::*;

   logic [6:0]             phase_ff, phase_in;
   logic [4:0]             hour_ff, hour_in;
   logic [5:0]             minute_ff, minute_in;
   logic [5:0]             second_ff, second_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [COUNT_WIDTH-1:0] latched_ff, latched_in;
   logic [COUNT_WIDTH-1:0] lap_ff [LAP_DEPTH];
   logic [COUNT_WIDTH-1:0] lap_in [LAP_DEPTH];
   logic                   running_ff, running_in;
   logic                   in_lap_ff, in_lap_in;
   logic                   recorded_ff, recorded_in;
   logic                   edit_min_ff, edit_min_in;
   mode_type               mode_ff, mode_in;
   logic [4:0]             al_hour_ff, al_hour_in;
   logic [5:0]             al_minute_ff, al_minute_in;
   logic                   al_enabled_ff, al_enabled_in;

   mode_type   mode_w;
   logic       clk_upd, sw_upd, push, clear_lap, roll_min;
   logic [6:0] snooze_sum;

   always_comb begin
      phase_in      = phase_ff;
      hour_in       = hour_ff;
      minute_in     = minute_ff;
      second_in     = second_ff;
      count_in      = count_ff;
      latched_in    = latched_ff;
      lap_in        = lap_ff;
      running_in    = running_ff;
      in_lap_in     = in_lap_ff;
      recorded_in   = recorded_ff;
      edit_min_in   = edit_min_ff;
      al_hour_in    = al_hour_ff;
      al_minute_in  = al_minute_ff;
      al_enabled_in = al_enabled_ff;
      clk_upd       = 1'b0;
      sw_upd        = 1'b0;
      push          = 1'b0;
      clear_lap     = 1'b0;
      roll_min      = 1'b0;
      snooze_sum    = {1'b0, al_minute_ff} + SNOOZE_MIN;

      mode_w  = item.mode_write ? sat_mode(item.mode_value) : mode_ff;
      mode_in = mode_w;

      unique case (item.func)
         FUNC_LOAD_CLOCK: begin
            hour_in    = sat_hour(item.hour);
            minute_in  = sat_sixty(item.minute);
            second_in  = sat_sixty(item.second);
            latched_in = '0;
            clk_upd    = (mode_w == MODE_TIMEKEEP) || (mode_w == MODE_SET);
         end
         FUNC_LOAD_ALARM: begin
            al_hour_in    = sat_hour(item.hour);
            al_minute_in  = sat_sixty(item.minute);
            al_enabled_in = item.alarm_on;
         end
         FUNC_TICK: begin
            if (mode_w == MODE_SET) begin
               // time frozen, buttons step the edited field
               if (item.start_stop) begin
                  if (!edit_min_ff) begin
                     hour_in = (hour_ff >= HOUR_TOP) ? '0 : hour_ff + 5'd1;
                  end else begin
                     minute_in = (minute_ff >= MINUTE_TOP) ? '0 : minute_ff + 6'd1;
                  end
                  latched_in = '0;
                  clk_upd    = 1'b1;
               end
               if (item.reset_button) begin
                  edit_min_in = !edit_min_ff;
               end
            end else begin
               if (mode_w == MODE_WATCH) begin
                  if (item.start_stop) begin
                     if (!running_ff && !in_lap_ff) begin
                        running_in  = 1'b1;
                        recorded_in = 1'b0;
                     end else if (running_ff) begin
                        running_in  = 1'b0;
                        in_lap_in   = 1'b1;
                        recorded_in = 1'b0;
                     end else begin
                        in_lap_in  = 1'b0;
                        running_in = 1'b1;
                     end
                     sw_upd = 1'b1;
                  end
                  if (!in_lap_ff) begin
                     latched_in = count_ff;
                  end
                  // at most one push per lap, of the frozen display value
                  push = in_lap_ff && !recorded_ff;
                  if (push) begin
                     recorded_in = 1'b1;
                     for (int i = LAP_DEPTH - 1; i > 0; i--) begin
                        lap_in[i] = lap_ff[i-1];
                     end
                     lap_in[0] = latched_ff;
                  end
                  clear_lap = item.reset_button && in_lap_ff;
                  if (clear_lap) begin
                     latched_in = '0;
                     for (int i = 0; i < LAP_DEPTH; i++) begin
                        lap_in[i] = '0;
                     end
                     in_lap_in = 1'b0;
                     sw_upd    = 1'b1;
                  end
                  if (running_ff) begin
                     sw_upd = 1'b1;
                  end
               end

               if (running_ff || in_lap_ff) begin
                  count_in = clear_lap ? COUNT_WIDTH'(1) : count_ff + COUNT_WIDTH'(1);
               end

               if (phase_ff >= PHASE_TOP) begin
                  phase_in = '0;
                  if (second_ff >= SECOND_TOP) begin
                     second_in = '0;
                     roll_min  = 1'b1;
                  end else begin
                     second_in = second_ff + 6'd1;
                  end
                  if (roll_min) begin
                     if (minute_ff >= MINUTE_TOP) begin
                        minute_in = '0;
                        hour_in   = (hour_ff >= HOUR_TOP) ? '0 : hour_ff + 5'd1;
                     end else begin
                        minute_in = minute_ff + 6'd1;
                     end
                  end
                  clk_upd = (mode_w == MODE_TIMEKEEP);
               end else begin
                  phase_in = phase_ff + 7'd1;
               end

               // snooze moves the alarm five minutes on, wrapping at midnight
               if ((mode_w == MODE_RING) && item.reset_button) begin
                  if (snooze_sum >= HOUR_MINS) begin
                     al_minute_in = 6'(snooze_sum - HOUR_MINS);
                     al_hour_in   = (al_hour_ff >= HOUR_TOP) ? '0 : al_hour_ff + 5'd1;
                  end else begin
                     al_minute_in = snooze_sum[5:0];
                  end
                  mode_in = MODE_TIMEKEEP;
               end

               if (al_enabled_ff && (hour_in == al_hour_in) && (minute_in == al_minute_in)) begin
                  mode_in = MODE_RING;
               end
            end
         end
         default: ;
      endcase

      result.clock_hour       = hour_in;
      result.clock_minute     = minute_in;
      result.clock_second     = second_in;
      result.clock_update     = clk_upd;
      result.stopwatch_shown  = latched_in;
      result.lap_newest       = lap_in[0];
      result.lap_second       = lap_in[1];
      result.lap_third        = lap_in[2];
      result.lap_oldest       = lap_in[3];
      result.stopwatch_update = sw_upd;
      result.mode_now         = mode_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= '0;
         hour_ff       <= '0;
         minute_ff     <= '0;
         second_ff     <= '0;
         count_ff      <= '0;
         latched_ff    <= '0;
         for (int i = 0; i < LAP_DEPTH; i++) begin
            lap_ff[i] <= '0;
         end
         running_ff    <= 1'b0;
         in_lap_ff     <= 1'b0;
         recorded_ff   <= 1'b0;
         edit_min_ff   <= 1'b0;
         mode_ff       <= MODE_TIMEKEEP;
         al_hour_ff    <= '0;
         al_minute_ff  <= '0;
         al_enabled_ff <= 1'b0;
      end else if (fire) begin
         phase_ff      <= phase_in;
         hour_ff       <= hour_in;
         minute_ff     <= minute_in;
         second_ff     <= second_in;
         count_ff      <= count_in;
         latched_ff    <= latched_in;
         lap_ff        <= lap_in;
         running_ff    <= running_in;
         in_lap_ff     <= in_lap_in;
         recorded_ff   <= recorded_in;
         edit_min_ff   <= edit_min_in;
         mode_ff       <= mode_in;
         al_hour_ff    <= al_hour_in;
         al_minute_ff  <= al_minute_in;
         al_enabled_ff <= al_enabled_in;
      end
   end

endmodule

/* sv/clock_stopwatch_alarm_top.sv */
// top level of the digital clock with stopwatch, lap history and alarm
//
// usage
//   request channel (req_): one transaction per 10 ms tick, clock load or alarm load,
//   carrying button presses and an optional mode write; accepted on a clock edge
//   with req_valid high and req_stall low
//   response channel (rsp_): exactly one transaction per request, in order, with
//   the time, stopwatch display, four lap times, update flags and current mode
//   path: a request passes through the input register, then the result register
//   loaded by the single-pass state update, which a response stall can hold back
//   throughput: one transaction per cycle while the response side does not stall;
//   every item updates the whole state in one pass between the input and result
//   registers
//   stall: while rsp_stall holds a waiting response, one more request is still
//   taken into the input register; req_stall rises only when both registers are
//   full and the response side stalls
//   reset: synchronous, clears both valid flags and all state to 00:00:00, the
//   stopwatch idle at zero, clock mode and the alarm disabled
`timescale 1ns / 1ps

module clock_stopwatch_alarm_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_func,
   input  logic [4:0]                      req_hour,
   input  logic [5:0]                      req_minute,
   input  logic [5:0]                      req_second,
   input  logic                            req_alarm_on,
   input  logic                            req_mode_write,
   input  logic [2:0]                      req_mode_value,
   input  logic                            req_start_stop,
   input  logic                            req_reset_button,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [4:0]                      rsp_clock_hour,
   output logic [5:0]                      rsp_clock_minute,
   output logic [5:0]                      rsp_clock_second,
   output logic                            rsp_clock_update,
   output logic [csa_pkg::COUNT_WIDTH-1:0] rsp_stopwatch_shown,
   output logic [csa_pkg::COUNT_WIDTH-1:0] rsp_lap_newest,
   output logic [csa_pkg::COUNT_WIDTH-1:0] rsp_lap_second,
   output logic [csa_pkg::COUNT_WIDTH-1:0] rsp_lap_third,
   output logic [csa_pkg::COUNT_WIDTH-1:0] rsp_lap_oldest,
   output logic                            rsp_stopwatch_update,
   output logic [2:0]                      rsp_mode_now
);
   import csa_pkg::*;

   // input register
   req_type item_ff, item_in;
   logic    item_valid_ff, item_valid_in;

   // result register
   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff, rsp_valid_in;

   logic advance;   // item moves from input register into result register

   assign advance   = item_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = item_valid_ff && rsp_valid_ff && rsp_stall;

   always_comb begin
      item_in.func         = req_func;
      item_in.hour         = req_hour;
      item_in.minute       = req_minute;
      item_in.second       = req_second;
      item_in.alarm_on     = req_alarm_on;
      item_in.mode_write   = req_mode_write;
      item_in.mode_value   = req_mode_value;
      item_in.start_stop   = req_start_stop;
      item_in.reset_button = req_reset_button;

      // input register refills whenever it is not held back
      item_valid_in = req_stall ? item_valid_ff : req_valid;

      // result register keeps a stalled response, otherwise takes what advances
      rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);
   end

   // state lives in the core and updates on each advancing item
   csa_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (item_ff),
      .result (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         item_ff <= item_in;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_clock_hour       = rsp_ff.clock_hour;
   assign rsp_clock_minute     = rsp_ff.clock_minute;
   assign rsp_clock_second     = rsp_ff.clock_second;
   assign rsp_clock_update     = rsp_ff.clock_update;
   assign rsp_stopwatch_shown  = rsp_ff.stopwatch_shown;
   assign rsp_lap_newest       = rsp_ff.lap_newest;
   assign rsp_lap_second       = rsp_ff.lap_second;
   assign rsp_lap_third        = rsp_ff.lap_third;
   assign rsp_lap_oldest       = rsp_ff.lap_oldest;
   assign rsp_stopwatch_update = rsp_ff.stopwatch_update;
   assign rsp_mode_now         = rsp_ff.mode_now;

endmodule

/* sv/csa_checker.sv */
// port-level checker for the clock, stopwatch and alarm block, with its bind
`timescale 1ns / 1ps

module csa_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [4:0]                      rsp_clock_hour,
   input logic [5:0]                      rsp_clock_minute,
   input logic [5:0]                      rsp_clock_second,
   input logic [csa_pkg::COUNT_WIDTH-1:0] rsp_stopwatch_shown,
   input logic                            rsp_stopwatch_update,
   input logic [2:0]                      rsp_mode_now
);
   import csa_pkg::*;

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_clock_hour)
         && $stable(rsp_clock_minute) && $stable(rsp_stopwatch_shown))
      else $error("stalled response changed");

   // requests are held back only when a response is waiting and stalled
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a stalled response");

   // time of day stays in range
   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_clock_hour <= HOUR_TOP) && (rsp_clock_minute <= MINUTE_TOP)
         && (rsp_clock_second <= SECOND_TOP))
      else $error("time of day out of range");

   // stopwatch refresh only happens in stopwatch mode or on an alarm taking over
   a_sw_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stopwatch_update |->
         (rsp_mode_now == MODE_WATCH) || (rsp_mode_now == MODE_RING))
      else $error("stopwatch update outside stopwatch mode");

endmodule

bind clock_stopwatch_alarm_top csa_checker u_csa_checker (.*);

/* sim/clock_stopwatch_alarm_checker.sv */
// response checker for the clock, stopwatch and alarm block: predicts every display and compares
`timescale 1ns / 1ps

module clock_stopwatch_alarm_checker
   import csa_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_item,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_item,
   output int      outstanding,
   output int      fail_count
);

   // predicted state of the block
   logic [6:0]             phase;
   logic [4:0]             hour_now;
   logic [5:0]             minute_now;
   logic [5:0]             second_now;
   logic [COUNT_WIDTH-1:0] count_now;
   logic [COUNT_WIDTH-1:0] shown_now;
   logic [COUNT_WIDTH-1:0] laps [LAP_DEPTH];
   logic                   running;
   logic                   in_lap;
   logic                   lap_saved;
   logic                   edit_minutes;
   mode_type               mode;
   logic [4:0]             alarm_hour;
   logic [5:0]             alarm_minute;
   logic                   alarm_enabled;

   rsp_type expected_displays [$];

   task automatic clear_model();
      phase         = '0;
      hour_now      = '0;
      minute_now    = '0;
      second_now    = '0;
      count_now     = '0;
      shown_now     = '0;
      for (int i = 0; i < LAP_DEPTH; i++) laps[i] = '0;
      running       = 1'b0;
      in_lap        = 1'b0;
      lap_saved     = 1'b0;
      edit_minutes  = 1'b0;
      mode          = MODE_TIMEKEEP;
      alarm_hour    = '0;
      alarm_minute  = '0;
      alarm_enabled = 1'b0;
   endtask

   task automatic save_lap();
      for (int i = LAP_DEPTH - 1; i > 0; i--) laps[i] = laps[i-1];
      laps[0]   = shown_now;
      lap_saved = 1'b1;
   endtask

   task automatic predict_display(input req_type item, output rsp_type display);
      logic was_running;
      logic was_lap;
      logic clock_changed;
      logic watch_changed;
      int   day_minutes;
      clock_changed = 1'b0;
      watch_changed = 1'b0;

      // the mode write lands before anything else
      if (item.mode_write)
         mode = (item.mode_value > MODE_OTHER) ? MODE_OTHER : mode_type'(item.mode_value);

      case (func_type'(item.func))
         FUNC_LOAD_CLOCK: begin
            hour_now      = (item.hour > HOUR_TOP) ? HOUR_TOP : item.hour;
            minute_now    = (item.minute > MINUTE_TOP) ? MINUTE_TOP : item.minute;
            second_now    = (item.second > SECOND_TOP) ? SECOND_TOP : item.second;
            shown_now     = '0;
            clock_changed = (mode == MODE_TIMEKEEP || mode == MODE_SET);
         end
         FUNC_LOAD_ALARM: begin
            alarm_hour    = (item.hour > HOUR_TOP) ? HOUR_TOP : item.hour;
            alarm_minute  = (item.minute > MINUTE_TOP) ? MINUTE_TOP : item.minute;
            alarm_enabled = item.alarm_on;
         end
         FUNC_TICK: begin
            if (mode == MODE_SET) begin
               // time frozen, buttons step the hour or the minute
               if (item.start_stop) begin
                  if (!edit_minutes)
                     hour_now = (hour_now == HOUR_TOP) ? 5'd0 : hour_now + 5'd1;
                  else
                     minute_now = (minute_now == MINUTE_TOP) ? 6'd0 : minute_now + 6'd1;
                  shown_now     = '0;
                  clock_changed = 1'b1;
               end
               if (item.reset_button) edit_minutes = !edit_minutes;
            end else begin
               was_running = running;
               was_lap     = in_lap;
               if (mode == MODE_WATCH) begin
                  if (item.start_stop) begin
                     if (!was_running && !was_lap) begin
                        running   = 1'b1;
                        lap_saved = 1'b0;
                     end else if (was_running) begin
                        running   = 1'b0;
                        in_lap    = 1'b1;
                        lap_saved = 1'b0;
                     end else begin
                        in_lap  = 1'b0;
                        running = 1'b1;
                        if (!lap_saved) save_lap();
                     end
                     watch_changed = 1'b1;
                  end
                  if (!was_lap) shown_now = count_now;
                  if (was_lap && !lap_saved) save_lap();
                  if (item.reset_button && was_lap) begin
                     count_now = '0;
                     shown_now = '0;
                     for (int i = 0; i < LAP_DEPTH; i++) laps[i] = '0;
                     in_lap        = 1'b0;
                     watch_changed = 1'b1;
                  end
                  if (was_running) watch_changed = 1'b1;
               end

               if (was_running || was_lap) count_now = count_now + 1'b1;

               if (phase == PHASE_TOP) begin
                  phase = '0;
                  if (second_now == SECOND_TOP) begin
                     second_now = '0;
                     if (minute_now == MINUTE_TOP) begin
                        minute_now = '0;
                        hour_now   = (hour_now == HOUR_TOP) ? 5'd0 : hour_now + 5'd1;
                     end else begin
                        minute_now = minute_now + 6'd1;
                     end
                  end else begin
                     second_now = second_now + 6'd1;
                  end
                  clock_changed = (mode == MODE_TIMEKEEP || mode == MODE_SET);
               end else begin
                  phase = phase + 7'd1;
               end

               // snooze moves the alarm later, wrapping past midnight
               if (mode == MODE_RING && item.reset_button) begin
                  day_minutes  = (int'(alarm_hour) * int'(HOUR_MINS) + int'(alarm_minute)
                                 + int'(SNOOZE_MIN)) % (24 * int'(HOUR_MINS));
                  alarm_hour   = 5'(day_minutes / int'(HOUR_MINS));
                  alarm_minute = 6'(day_minutes % int'(HOUR_MINS));
                  mode         = MODE_TIMEKEEP;
               end

               if (alarm_enabled && hour_now == alarm_hour && minute_now == alarm_minute)
                  mode = MODE_RING;
            end
         end
         default: ;
      endcase

      display.clock_hour       = hour_now;
      display.clock_minute     = minute_now;
      display.clock_second     = second_now;
      display.clock_update     = clock_changed;
      display.stopwatch_shown  = shown_now;
      display.lap_newest       = laps[0];
      display.lap_second       = laps[1];
      display.lap_third        = laps[2];
      display.lap_oldest       = laps[3];
      display.stopwatch_update = watch_changed;
      display.mode_now         = mode;
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : watch_channels
      rsp_type want;
      if (reset) begin
         clear_model();
         expected_displays.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_displays.size() == 0) begin
               $error("response transaction with no request outstanding");
               fail_count++;
            end else begin
               want = expected_displays.pop_front();
               check_field("clock_hour", want.clock_hour, rsp_item.clock_hour);
               check_field("clock_minute", want.clock_minute, rsp_item.clock_minute);
               check_field("clock_second", want.clock_second, rsp_item.clock_second);
               check_field("clock_update", want.clock_update, rsp_item.clock_update);
               check_field("stopwatch_shown", want.stopwatch_shown, rsp_item.stopwatch_shown);
               check_field("lap_newest", want.lap_newest, rsp_item.lap_newest);
               check_field("lap_second", want.lap_second, rsp_item.lap_second);
               check_field("lap_third", want.lap_third, rsp_item.lap_third);
               check_field("lap_oldest", want.lap_oldest, rsp_item.lap_oldest);
               check_field("stopwatch_update", want.stopwatch_update,
                           rsp_item.stopwatch_update);
               check_field("mode_now", want.mode_now, rsp_item.mode_now);
            end
         end
         if (req_valid && !req_stall) begin
            predict_display(req_item, want);
            expected_displays.push_back(want);
         end
      end
      outstanding = expected_displays.size();
   end

endmodule

/* sim/clock_stopwatch_alarm_top_test.sv */
// testbench top for the clock, stopwatch and alarm block: stimulus, flow control and verdict
`timescale 1ns / 1ps

module clock_stopwatch_alarm_top_test;
   import csa_pkg::*;

   localparam int RANDOM_ITEMS = 1350;   // rough size of the random part
   localparam int CALM_TAIL    = 200;    // last stretch runs with no idling at all
   localparam int HOLD_CYCLES  = 80;     // long response hold-off, fills the pipeline
   localparam int DRAIN_CYCLES = 8;      // settling time after the final drain
   localparam int CYCLE_LIMIT  = 400000; // watchdog bound on the whole run

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   req_type    req_drive;
   logic       rsp_valid;
   logic       rsp_stall;
   rsp_type    rsp_view;

   logic [4:0]             rsp_clock_hour;
   logic [5:0]             rsp_clock_minute;
   logic [5:0]             rsp_clock_second;
   logic                   rsp_clock_update;
   logic [COUNT_WIDTH-1:0] rsp_stopwatch_shown;
   logic [COUNT_WIDTH-1:0] rsp_lap_newest;
   logic [COUNT_WIDTH-1:0] rsp_lap_second;
   logic [COUNT_WIDTH-1:0] rsp_lap_third;
   logic [COUNT_WIDTH-1:0] rsp_lap_oldest;
   logic                   rsp_stopwatch_update;
   logic [2:0]             rsp_mode_now;

   int outstanding;
   int fail_count;
   int items_sent;
   int cycle_count;
   bit idling_on;
   bit long_hold;

   // 8 ns clock
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   clock_stopwatch_alarm_top dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_func             (req_drive.func),
      .req_hour             (req_drive.hour),
      .req_minute           (req_drive.minute),
      .req_second           (req_drive.second),
      .req_alarm_on         (req_drive.alarm_on),
      .req_mode_write       (req_drive.mode_write),
      .req_mode_value       (req_drive.mode_value),
      .req_start_stop       (req_drive.start_stop),
      .req_reset_button     (req_drive.reset_button),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_clock_hour       (rsp_clock_hour),
      .rsp_clock_minute     (rsp_clock_minute),
      .rsp_clock_second     (rsp_clock_second),
      .rsp_clock_update     (rsp_clock_update),
      .rsp_stopwatch_shown  (rsp_stopwatch_shown),
      .rsp_lap_newest       (rsp_lap_newest),
      .rsp_lap_second       (rsp_lap_second),
      .rsp_lap_third        (rsp_lap_third),
      .rsp_lap_oldest       (rsp_lap_oldest),
      .rsp_stopwatch_update (rsp_stopwatch_update),
      .rsp_mode_now         (rsp_mode_now)
   );

   // response fields gathered in the package layout for the checker
   assign rsp_view = {rsp_clock_hour, rsp_clock_minute, rsp_clock_second, rsp_clock_update,
                      rsp_stopwatch_shown, rsp_lap_newest, rsp_lap_second, rsp_lap_third,
                      rsp_lap_oldest, rsp_stopwatch_update, rsp_mode_now};

   clock_stopwatch_alarm_checker checker_inst (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_item    (req_drive),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_item    (rsp_view),
      .outstanding (outstanding),
      .fail_count  (fail_count)
   );

   // watchdog, ends a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** clock_stopwatch_alarm_top: FAILED **");
         $finish;
      end
   end

   // every field random over its full width, unused fields included
   function automatic req_type random_item();
      req_type item;
      item.func         = 2'($urandom_range(0, 3));
      item.hour         = 5'($urandom_range(0, 31));
      item.minute       = 6'($urandom_range(0, 63));
      item.second       = 6'($urandom_range(0, 63));
      item.alarm_on     = 1'($urandom_range(0, 1));
      item.mode_write   = 1'($urandom_range(0, 1));
      item.mode_value   = 3'($urandom_range(0, 7));
      item.start_stop   = 1'($urandom_range(0, 1));
      item.reset_button = 1'($urandom_range(0, 1));
      return item;
   endfunction

   function automatic req_type tick_item(logic ss, logic rb);
      req_type item;
      item              = random_item();
      item.func         = FUNC_TICK;
      item.mode_write   = 1'b0;
      item.start_stop   = ss;
      item.reset_button = rb;
      return item;
   endfunction

   function automatic req_type mode_item(logic [2:0] mode, logic ss, logic rb);
      req_type item;
      item            = tick_item(ss, rb);
      item.mode_write = 1'b1;
      item.mode_value = mode;
      return item;
   endfunction

   function automatic req_type load_item(func_type kind, logic [4:0] h, logic [5:0] m,
                                         logic [5:0] s, logic on);
      req_type item;
      item            = random_item();
      item.func       = kind;
      item.hour       = h;
      item.minute     = m;
      item.second     = s;
      item.alarm_on   = on;
      item.mode_write = 1'b0;
      return item;
   endfunction

   // offer one transaction at the falling edge, hold it until taken, maybe idle after
   task automatic drive_item(input req_type item);
      req_drive = item;
      req_valid = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      @(negedge clock);
      if (idling_on && $urandom_range(0, 5) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
   endtask

   // sender stops until every response is back
   task automatic drain_responses();
      req_valid = 1'b0;
      wait (outstanding == 0);
      @(negedge clock);
   endtask

   // plain timekeeping, often loaded just before a minute or midnight rollover
   task automatic run_clock_stretch();
      req_type item;
      int      n;
      item = load_item(FUNC_LOAD_CLOCK,
                       ($urandom_range(0, 2) == 0) ? 5'd23 : 5'($urandom_range(0, 23)),
                       ($urandom_range(0, 1) == 0) ? 6'd59 : 6'($urandom_range(0, 59)),
                       ($urandom_range(0, 1) == 0) ? 6'd59 : 6'($urandom_range(0, 59)),
                       1'b0);
      item.mode_write = 1'b1;
      item.mode_value = ($urandom_range(0, 3) == 0) ? MODE_OTHER : MODE_TIMEKEEP;
      drive_item(item);
      n = $urandom_range(40, 160);
      repeat (n) begin
         if ($urandom_range(0, 49) == 0)
            drive_item(mode_item(3'($urandom_range(0, 7)), 1'b0, 1'b0));
         else
            drive_item(tick_item($urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0));
      end
   endtask

   // start, lap, resume and reset presses spaced by runs of ticks, with the odd clock load
   task automatic run_stopwatch_session();
      int presses;
      int gap;
      int pick;
      if ($urandom_range(0, 3) != 0)
         drive_item(load_item(FUNC_LOAD_ALARM, 5'($urandom_range(0, 31)),
                              6'($urandom_range(0, 63)), 6'd0, 1'b0));
      drive_item(mode_item(MODE_WATCH, 1'b1, 1'b0));
      presses = $urandom_range(4, 12);
      repeat (presses) begin
         gap = $urandom_range(0, 25);
         repeat (gap) drive_item(tick_item(1'b0, 1'b0));
         pick = $urandom_range(0, 9);
         if (pick == 0)
            drive_item(load_item(FUNC_LOAD_CLOCK, 5'($urandom_range(0, 31)),
                                 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)), 1'b0));
         else if (pick < 3)
            drive_item(tick_item(1'b0, 1'b1));
         else if (pick == 3)
            drive_item(tick_item(1'b1, 1'b1));
         else
            drive_item(tick_item(1'b1, 1'b0));
      end
   endtask

   // alarm set on the current or the next minute, then ticks with the odd snooze, press or mode write
   task automatic run_alarm_session();
      logic [4:0] h;
      logic [5:0] m;
      req_type    item;
      int         n;
      int         pick;
      h    = 5'($urandom_range(0, 23));
      m    = 6'($urandom_range(0, 58));
      item = load_item(FUNC_LOAD_CLOCK, h, m, 6'(58 + $urandom_range(0, 1)), 1'b0);
      item.mode_write = 1'b1;
      item.mode_value = MODE_TIMEKEEP;
      drive_item(item);
      if ($urandom_range(0, 1) == 0)
         drive_item(load_item(FUNC_LOAD_ALARM, h, m, 6'd0, 1'b1));
      else
         drive_item(load_item(FUNC_LOAD_ALARM, h, m + 6'd1, 6'd0, $urandom_range(0, 3) != 0));
      n = $urandom_range(30, 160);
      repeat (n) begin
         pick = $urandom_range(0, 39);
         if (pick == 0)
            drive_item(mode_item(3'($urandom_range(0, 4)), 1'b0, 1'b0));
         else if (pick < 3)
            drive_item(tick_item(1'b0, 1'b1));
         else if (pick == 3)
            drive_item(tick_item(1'b1, 1'b0));
         else
            drive_item(tick_item(1'b0, 1'b0));
      end
   endtask

   // clock-set mode with random stepping and field toggling
   task automatic run_set_session();
      drive_item(mode_item(MODE_SET, 1'b0, 1'b0));
      repeat ($urandom_range(5, 20))
         drive_item(tick_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
   endtask

   task automatic run_noise();
      repeat ($urandom_range(5, 20)) drive_item(random_item());
   endtask

   // response side: random stall bursts, plus one long hold-off on request
   initial begin
      bit hold_used;
      rsp_stall = 1'b0;
      hold_used = 1'b0;
      wait (reset == 1'b0);
      forever begin
         @(negedge clock);
         if (long_hold && !hold_used) begin
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_stall = 1'b0;
            hold_used = 1'b1;
         end else if (idling_on && $urandom_range(0, 4) == 0) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(1, 9)) @(negedge clock);
            rsp_stall = 1'b0;
         end
      end
   end

   // request side: directed opening, random sessions, drain and verdict
   initial begin
      int random_start;
      int pick;
      bit hold_done;
      bit pause_done;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_drive  = '0;
      idling_on  = 1'b1;
      long_hold  = 1'b0;
      hold_done  = 1'b0;
      pause_done = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // out-of-range loads saturate to 23:59:59 and an alarm at 23:59
      drive_item(load_item(FUNC_LOAD_CLOCK, 5'd31, 6'd63, 6'd63, 1'b0));
      drive_item(load_item(FUNC_LOAD_ALARM, 5'd31, 6'd63, 6'd0, 1'b1));
      // match rings, then snooze wraps the alarm past midnight
      drive_item(tick_item(1'b0, 1'b0));
      drive_item(tick_item(1'b0, 1'b1));
      // idle function with a mode write above the top mode value
      drive_item(load_item(FUNC_NOP, 5'd0, 6'd0, 6'd0, 1'b0));
      req_drive.mode_write = 1'b1;
      req_drive.mode_value = 3'd7;
      drive_item(req_drive);
      // clock set: hour wraps 23 to 0, switch to minutes, minute wraps 59 to 0
      drive_item(mode_item(MODE_SET, 1'b1, 1'b0));
      drive_item(tick_item(1'b0, 1'b1));
      drive_item(tick_item(1'b1, 1'b0));
      drive_item(tick_item(1'b1, 1'b1));
      drive_item(load_item(FUNC_LOAD_CLOCK, 5'd0, 6'd0, 6'd0, 1'b1));
      // stopwatch: run, lap with its lap push, resume, lap again, reset inside lap
      drive_item(mode_item(MODE_WATCH, 1'b1, 1'b0));
      drive_item(tick_item(1'b0, 1'b0));
      drive_item(tick_item(1'b0, 1'b0));
      drive_item(tick_item(1'b1, 1'b0));
      drive_item(tick_item(1'b0, 1'b0));
      drive_item(tick_item(1'b1, 1'b0));
      drive_item(tick_item(1'b1, 1'b0));
      drive_item(tick_item(1'b0, 1'b1));
      // clock load outside clock modes, then a match overriding a mode write
      drive_item(load_item(FUNC_LOAD_CLOCK, 5'd5, 6'd6, 6'd7, 1'b0));
      drive_item(load_item(FUNC_LOAD_ALARM, 5'd5, 6'd6, 6'd0, 1'b1));
      drive_item(mode_item(MODE_WATCH, 1'b0, 1'b0));
      drive_item(tick_item(1'b0, 1'b1));
      drive_item(load_item(FUNC_LOAD_ALARM, 5'd0, 6'd0, 6'd0, 1'b0));
      drain_responses();

      random_start = items_sent;
      while (items_sent - random_start < RANDOM_ITEMS) begin
         idling_on = (items_sent - random_start < RANDOM_ITEMS - CALM_TAIL)
                     && ($urandom_range(0, 3) != 0);
         // one long response hold-off while requests keep coming
         if (!hold_done && items_sent - random_start > 400) begin
            long_hold = 1'b1;
            hold_done = 1'b1;
         end
         // one full stop of the sender until nothing is outstanding
         if (!pause_done && items_sent - random_start > 900) begin
            drain_responses();
            pause_done = 1'b1;
         end
         pick = $urandom_range(0, 9);
         if (pick < 2)
            run_clock_stretch();
         else if (pick < 5)
            run_stopwatch_session();
         else if (pick < 7)
            run_alarm_session();
         else if (pick == 7)
            run_set_session();
         else
            run_noise();
      end

      drain_responses();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("** clock_stopwatch_alarm_top: PASSED **");
      else
         $display("** clock_stopwatch_alarm_top: FAILED **");
      $finish;
   end

endmodule

/* filelist.f */
sv/csa_pkg.sv
sv/csa_core.sv
sv/clock_stopwatch_alarm_top.sv
sv/csa_checker.sv
sim/clock_stopwatch_alarm_checker.sv
sim/clock_stopwatch_alarm_top_test.sv
